// File: src/fclt_pkg.sv
// Shared types and constants for the dense layer training engine.
// No dependencies; imported by fclt_div and fully_connected_layer_train.
package fclt_pkg;

  localparam int MAX_IN    = 64;
  localparam int MAX_OUT   = 64;
  localparam int MAX_BATCH = 16;

  // serial divider: scaled SGD step divided by the batch size
  localparam int DIVD_W = 24;
  localparam int DIVR_W = 5;
  localparam int DCNT_W = $clog2(DIVD_W + 1);

  localparam int ACC_W  = 38;
  localparam int PROD_W = 16 + ACC_W;

  typedef enum logic [2:0] {
    CMD_LOAD_W = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_ACT    = 3'd2,
    CMD_FWD    = 3'd3,
    CMD_GRAD   = 3'd4,
    CMD_BWD    = 3'd5,
    CMD_UPD    = 3'd6
  } cmd_e;

  localparam logic [1:0] KIND_FWD = 2'd0;
  localparam logic [1:0] KIND_BWD = 2'd1;
  localparam logic [1:0] KIND_UPD = 2'd2;

  localparam logic [1:0] CFG_IN_CNT  = 2'd0;
  localparam logic [1:0] CFG_OUT_CNT = 2'd1;
  localparam logic [1:0] CFG_BAT_CNT = 2'd2;
  localparam logic [1:0] CFG_LRATE   = 2'd3;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// File: src/fclt_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on fclt_pkg for widths.
module fclt_div import fclt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0] quot_q;
  logic [DIVR_W-1:0] rem_q;
  logic [DIVR_W-1:0] dvsr_q;
  logic [DIVR_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quot_q[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIVD_W-2:0], ge};
      rem_q  <= ge ? DIVR_W'(rem_sh - {1'b0, dvsr_q}) : rem_sh[DIVR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/fully_connected_layer_train.sv
// Dense layer engine: forward, backward and SGD update on Q4.12 values.
// Depends on fclt_pkg and fclt_div.
//
// Load and store commands complete in the cycle they are taken and busy
// never rises. Forward, backward and update raise busy until their last
// result beat has gone out. One 16x16 multiply-accumulate does all sums,
// one product per cycle from the registered store reads. Update works on
// each weight and bias in turn through the serial divider that scales the
// step by the batch size, then sends one completion beat. Result beats
// come as one-cycle valid_o strobes and cannot be held off.
module fully_connected_layer_train import fclt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [2:0]         cmd_i,
  input  logic [3:0]         sample_index_i,
  input  logic [5:0]         in_index_i,
  input  logic [5:0]         out_index_i,
  input  logic signed [15:0] value_i,
  output logic               valid_o,
  output logic [1:0]         kind_o,
  output logic [5:0]         position_o,
  output logic signed [15:0] value_res_o,
  output logic               last_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MAC   = 9'b000000010,
    S_BIAS  = 9'b000000100,
    S_ABS   = 9'b000001000,
    S_OUT   = 9'b000010000,
    S_SCALE = 9'b000100000,
    S_OFFS  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_APPLY = 9'b100000000
  } state_e;

  state_e state_q;

  logic [6:0]  in_cnt_q, out_cnt_q;
  logic [4:0]  bat_cnt_q;
  logic [15:0] lr_q;
  logic [6:0]  ni, no;
  logic [4:0]  bc;

  cmd_e        mode_q;
  logic [3:0]  smp_q;
  logic [6:0]  oc_q, mc_q, ic_q;
  logic        upd_bias_q;
  logic        rd_v_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]  mag_q;
  logic              neg_q;
  logic [PROD_W-1:0] prod_q;

  logic        valid_q, last_q;
  logic [1:0]  kind_q;
  logic [5:0]  pos_q;
  logic signed [15:0] val_q;

  // stores
  logic signed [15:0] w_mem [MAX_IN*MAX_OUT];
  logic signed [15:0] b_mem [MAX_OUT];
  logic signed [15:0] a_mem [MAX_BATCH*MAX_IN];
  logic signed [15:0] g_mem [MAX_BATCH*MAX_OUT];
  logic signed [15:0] w_rd_q, b_rd_q, a_rd_q, g_rd_q;
  logic [11:0] w_ra;
  logic [9:0]  a_ra, g_ra;

  logic        go;
  logic        iss;
  logic [6:0]  len;
  logic signed [15:0] op_a, op_b;
  logic signed [31:0] mul;
  logic [PROD_W:0]    num;
  logic [PROD_W:0]    num_sh;
  logic               div_start, div_done;
  logic [DIVD_W-1:0]  quot;
  logic signed [15:0] old_v;
  logic signed [25:0] step_v;
  logic signed [15:0] new_v;
  logic [ACC_W:0]     rnd;
  logic signed [39:0] out_v;
  logic               w_we_load, w_we_upd, b_we_upd;

  assign busy = (state_q != S_IDLE);
  assign go   = start && !busy;

  assign ni = (in_cnt_q == 7'd0) ? 7'd1 : ((in_cnt_q > 7'(MAX_IN)) ? 7'(MAX_IN) : in_cnt_q);
  assign no = (out_cnt_q == 7'd0) ? 7'd1 :
              ((out_cnt_q > 7'(MAX_OUT)) ? 7'(MAX_OUT) : out_cnt_q);
  assign bc = (bat_cnt_q == 5'd0) ? 5'd1 :
              ((bat_cnt_q > 5'(MAX_BATCH)) ? 5'(MAX_BATCH) : bat_cnt_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= 7'd64;
      out_cnt_q <= 7'd64;
      bat_cnt_q <= 5'd1;
      lr_q      <= 16'd655;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_CNT:  in_cnt_q  <= cfg_data_i[6:0];
        CFG_OUT_CNT: out_cnt_q <= cfg_data_i[6:0];
        CFG_BAT_CNT: bat_cnt_q <= cfg_data_i[4:0];
        CFG_LRATE:   lr_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // read addresses follow the loop counters
  always_comb begin
    case (mode_q)
      CMD_FWD: begin
        len  = ni;
        a_ra = {smp_q, ic_q[5:0]};
        g_ra = {smp_q, ic_q[5:0]};
        w_ra = {ic_q[5:0], oc_q[5:0]};
      end
      CMD_BWD: begin
        len  = no;
        a_ra = {smp_q, ic_q[5:0]};
        g_ra = {smp_q, ic_q[5:0]};
        w_ra = {oc_q[5:0], ic_q[5:0]};
      end
      default: begin
        len  = {2'b00, bc};
        a_ra = {ic_q[3:0], mc_q[5:0]};
        g_ra = {ic_q[3:0], oc_q[5:0]};
        w_ra = {mc_q[5:0], oc_q[5:0]};
      end
    endcase
  end

  assign iss = (ic_q < len);

  always_comb begin
    case (mode_q)
      CMD_FWD: begin
        op_a = a_rd_q;
        op_b = w_rd_q;
      end
      CMD_BWD: begin
        op_a = w_rd_q;
        op_b = g_rd_q;
      end
      default: begin
        op_a = upd_bias_q ? 16'sd1 : a_rd_q;
        op_b = g_rd_q;
      end
    endcase
  end

  assign mul = op_a * op_b;

  // round half away from zero on the magnitude
  assign rnd   = {1'b0, mag_q} + (ACC_W+1)'(2048);
  assign out_v = neg_q ? -$signed({1'b0, 39'(rnd >> 12)}) : $signed({1'b0, 39'(rnd >> 12)});

  // rounding offset is half of bc * 2^shift
  assign num    = {1'b0, prod_q} + (upd_bias_q ? ((PROD_W+1)'(bc) << 15)
                                               : ((PROD_W+1)'(bc) << 27));
  assign num_sh = upd_bias_q ? (num >> 16) : (num >> 28);
  assign div_start = (state_q == S_OFFS);

  fclt_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (num_sh[DIVD_W-1:0]),
    .divisor_i  (bc),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign old_v  = upd_bias_q ? b_rd_q : w_rd_q;
  assign step_v = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign new_v  = sat16(40'(26'(26'(old_v) - step_v)));

  assign w_we_load = go && (cmd_e'(cmd_i) == CMD_LOAD_W);
  assign w_we_upd  = (state_q == S_APPLY) && !upd_bias_q;
  assign b_we_upd  = (state_q == S_APPLY) && upd_bias_q;

  always_ff @(posedge clk_i) begin
    if (w_we_load) begin
      w_mem[{in_index_i, out_index_i}] <= value_i;
    end else if (w_we_upd) begin
      w_mem[w_ra] <= new_v;
    end
    w_rd_q <= w_mem[w_ra];
  end

  always_ff @(posedge clk_i) begin
    if (go && (cmd_e'(cmd_i) == CMD_LOAD_B)) begin
      b_mem[out_index_i] <= value_i;
    end else if (b_we_upd) begin
      b_mem[oc_q[5:0]] <= new_v;
    end
    b_rd_q <= b_mem[oc_q[5:0]];
  end

  always_ff @(posedge clk_i) begin
    if (go && (cmd_e'(cmd_i) == CMD_ACT)) begin
      a_mem[{sample_index_i, in_index_i}] <= value_i;
    end
    a_rd_q <= a_mem[a_ra];
  end

  always_ff @(posedge clk_i) begin
    if (go && (cmd_e'(cmd_i) == CMD_GRAD)) begin
      g_mem[{sample_index_i, out_index_i}] <= value_i;
    end
    g_rd_q <= g_mem[g_ra];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= CMD_FWD;
      smp_q      <= '0;
      oc_q       <= '0;
      mc_q       <= '0;
      ic_q       <= '0;
      upd_bias_q <= 1'b0;
      rd_v_q     <= 1'b0;
      acc_q      <= '0;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      prod_q     <= '0;
      valid_q    <= 1'b0;
      kind_q     <= '0;
      pos_q      <= '0;
      val_q      <= '0;
      last_q     <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (go) begin
            oc_q       <= '0;
            mc_q       <= '0;
            ic_q       <= '0;
            acc_q      <= '0;
            rd_v_q     <= 1'b0;
            upd_bias_q <= 1'b1;
            smp_q      <= sample_index_i;
            case (cmd_e'(cmd_i))
              CMD_FWD, CMD_BWD, CMD_UPD: begin
                mode_q  <= cmd_e'(cmd_i);
                state_q <= S_MAC;
              end
              default: ;
            endcase
          end
        end
        S_MAC: begin
          rd_v_q <= iss;
          if (rd_v_q) begin
            acc_q <= acc_q + ACC_W'(mul);
          end
          if (iss) begin
            ic_q <= ic_q + 1'b1;
          end else if (!rd_v_q) begin
            state_q <= (mode_q == CMD_FWD) ? S_BIAS : S_ABS;
          end
        end
        S_BIAS: begin
          acc_q   <= acc_q + (ACC_W'(b_rd_q) <<< 12);
          state_q <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= acc_q[ACC_W-1];
          mag_q   <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
          state_q <= (mode_q == CMD_UPD) ? S_SCALE : S_OUT;
        end
        S_OUT: begin
          valid_q <= 1'b1;
          kind_q  <= (mode_q == CMD_FWD) ? KIND_FWD : KIND_BWD;
          pos_q   <= oc_q[5:0];
          val_q   <= sat16(out_v);
          last_q  <= (oc_q == ((mode_q == CMD_FWD) ? no : ni) - 7'd1);
          ic_q    <= '0;
          acc_q   <= '0;
          oc_q    <= oc_q + 1'b1;
          if (oc_q == ((mode_q == CMD_FWD) ? no : ni) - 7'd1) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MAC;
          end
        end
        S_SCALE: begin
          prod_q  <= lr_q * mag_q;
          state_q <= S_OFFS;
        end
        S_OFFS: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          ic_q    <= '0;
          acc_q   <= '0;
          state_q <= S_MAC;
          if (upd_bias_q) begin
            upd_bias_q <= 1'b0;
            mc_q       <= '0;
          end else if (mc_q == ni - 7'd1) begin
            if (oc_q == no - 7'd1) begin
              valid_q <= 1'b1;
              kind_q  <= KIND_UPD;
              pos_q   <= '0;
              val_q   <= '0;
              last_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              oc_q       <= oc_q + 1'b1;
              upd_bias_q <= 1'b1;
            end
          end else begin
            mc_q <= mc_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o     = valid_q;
  assign kind_o      = kind_q;
  assign position_o  = pos_q;
  assign value_res_o = val_q;
  assign last_o      = valid_q && last_q;

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without valid beat");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o && last_o) else $error("busy fell without last beat");

  a_upd_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KIND_UPD |-> position_o == 6'd0 && value_res_o == 16'sd0 && last_o)
    else $error("malformed update beat");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_FWD || cmd_i == CMD_BWD || cmd_i == CMD_UPD) |=> busy)
    else $error("compute command did not raise busy");

endmodule
